FILE: rtl/length_prefixed_record_fifo_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed record FIFO
// Shared concurrent assertion forms. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_RECORD_FIFO_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_RECORD_FIFO_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define LPRF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A condition that, once seen, forces another one on the next clock edge.
`define LPRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lprf_pkg.sv
// ----------------------------------------------------------------------------
// lprf_pkg
// Types and constants shared by the length-prefixed record FIFO modules.
// ----------------------------------------------------------------------------
package lprf_pkg;

  // Store geometry. Pointers carry one extra wrap bit over the address.
  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int LEN_W       = 12;
  localparam int HDR_BYTES   = 4;
  localparam int MAX_LEN     = STORE_BYTES / 2;

  // Input operation codes.
  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_CORRUPT   = 3'd3,
    ST_NO_RECORD = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_HLO,
    S_HHI,
    S_RDATA,
    S_OUT
  } state_t;

  // Input beat.
  typedef struct packed {
    logic [1:0]       func;
    logic [LEN_W-1:0] record_length;
    logic [7:0]       data_byte;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       read_data;
    logic             last;
    logic [LEN_W-1:0] current_length;
    logic [PTR_W-1:0] fill_level;
  } out_item_t;

  // Byte store access request for both ports.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/lprf_ram.sv
// ----------------------------------------------------------------------------
// lprf_ram
// Byte-wide store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lprf_ram (
  input  logic              clk,
  input  lprf_pkg::mem_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [lprf_pkg::STORE_BYTES];
  logic [7:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, read data registered.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/length_prefixed_record_fifo_core.sv
// Results wait in S_OUT during sink stalls and are registered once the output has room.
// Item sequencing: payload write, empty read, dropped begin and no-op go to S_OUT; a
// read inside a record goes via S_RDATA; a read at a record start via S_HLO and S_HHI
// (two header byte reads), then S_RDATA for the data read, or from S_HHI to S_OUT when
// the header is corrupt; a begin via S_HDR (four header byte writes).
// Reset (synchronous, active low) empties the store; the memory itself is not cleared.
// ----------------------------------------------------------------------------
// length_prefixed_record_fifo_core
// Circular byte store of length-prefixed records with commit-on-last-byte writes.
// ----------------------------------------------------------------------------
`include "length_prefixed_record_fifo_core_defines.svh"

module length_prefixed_record_fifo_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lprf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lprf_pkg::out_item_t  out_data
);

  localparam int PW = lprf_pkg::PTR_W;
  localparam int LW = lprf_pkg::LEN_W;
  localparam int AW = lprf_pkg::ADDR_W;

  lprf_pkg::state_t     state_r, state_nxt;
  logic [PW-1:0]        cwp_r, cwp_nxt;
  logic [PW-1:0]        swp_r, swp_nxt;
  logic [LW-1:0]        wbl_r, wbl_nxt;
  logic                 wopen_r, wopen_nxt;
  logic [PW-1:0]        rp_r, rp_nxt;
  logic [LW-1:0]        rbl_r, rbl_nxt;
  logic [LW-1:0]        rrl_r, rrl_nxt;
  logic [1:0]           hdr_cnt_r, hdr_cnt_nxt;
  logic [LW-1:0]        hdr_len_r, hdr_len_nxt;
  logic [7:0]           hdr_lo_r, hdr_lo_nxt;
  lprf_pkg::out_item_t  res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lprf_pkg::out_item_t  out_data_r, out_data_nxt;

  lprf_pkg::mem_req_t   mem_req;
  logic [7:0]           mem_rdata;

  logic                 accept;
  logic [PW-1:0]        fill;
  logic [PW-1:0]        avail;
  logic [PW-1:0]        total;
  logic [PW-1:0]        hdr_ptr;
  logic [15:0]          hdr_val;
  logic                 hdr_bad;
  logic                 out_free;

  // Byte store.
  lprf_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Handshake and occupancy arithmetic.
  assign in_stall = (state_r != lprf_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fill     = cwp_r - rp_r;
  assign avail    = PW'(lprf_pkg::STORE_BYTES) - fill;
  assign total    = PW'(in_data.record_length) + PW'(lprf_pkg::HDR_BYTES);
  assign hdr_ptr  = swp_r - PW'(lprf_pkg::HDR_BYTES) + PW'(hdr_cnt_r);
  assign hdr_val  = {mem_rdata, hdr_lo_r};
  assign hdr_bad  = (hdr_val == 16'd0) || (hdr_val > 16'(lprf_pkg::MAX_LEN));
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: next state, pointer updates and store accesses.
  always_comb begin
    state_nxt    = state_r;
    cwp_nxt      = cwp_r;
    swp_nxt      = swp_r;
    wbl_nxt      = wbl_r;
    wopen_nxt    = wopen_r;
    rp_nxt       = rp_r;
    rbl_nxt      = rbl_r;
    rrl_nxt      = rrl_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    hdr_len_nxt  = hdr_len_r;
    hdr_lo_nxt   = hdr_lo_r;
    res_nxt      = res_r;
    mem_req      = '0;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      lprf_pkg::S_IDLE: begin
        if (accept) begin
          res_nxt                = '0;
          res_nxt.status         = lprf_pkg::ST_OK;
          state_nxt              = lprf_pkg::S_OUT;
          unique case (in_data.func)
            lprf_pkg::FUNC_BEGIN: begin
              // Any open record is abandoned before the new one is checked.
              wopen_nxt              = 1'b0;
              swp_nxt                = cwp_r;
              wbl_nxt                = '0;
              res_nxt.current_length = in_data.record_length;
              if (total > avail) begin
                res_nxt.status = lprf_pkg::ST_DROPPED;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cwp_r[AW-1:0];
                mem_req.wdata = in_data.record_length[7:0];
                swp_nxt       = cwp_r + PW'(lprf_pkg::HDR_BYTES);
                hdr_len_nxt   = in_data.record_length;
                hdr_cnt_nxt   = 2'd1;
                state_nxt     = lprf_pkg::S_HDR;
                if (in_data.record_length == '0) begin
                  cwp_nxt = cwp_r + PW'(lprf_pkg::HDR_BYTES);
                end else begin
                  wbl_nxt   = in_data.record_length;
                  wopen_nxt = 1'b1;
                end
              end
            end
            lprf_pkg::FUNC_WRITE: begin
              if (!wopen_r) begin
                res_nxt.status = lprf_pkg::ST_NO_RECORD;
              end else begin
                res_nxt.current_length =
                  LW'(swp_r - cwp_r - PW'(lprf_pkg::HDR_BYTES) + PW'(wbl_r));
                mem_req.we    = 1'b1;
                mem_req.waddr = swp_r[AW-1:0];
                mem_req.wdata = in_data.data_byte;
                swp_nxt       = swp_r + PW'(1);
                wbl_nxt       = wbl_r - LW'(1);
                // Last byte commits the whole record.
                if (wbl_r == LW'(1)) begin
                  cwp_nxt      = swp_r + PW'(1);
                  wopen_nxt    = 1'b0;
                  res_nxt.last = 1'b1;
                end
              end
            end
            lprf_pkg::FUNC_READ: begin
              if (rbl_r != '0) begin
                mem_req.re             = 1'b1;
                mem_req.raddr          = rp_r[AW-1:0];
                rp_nxt                 = rp_r + PW'(1);
                rbl_nxt                = rbl_r - LW'(1);
                res_nxt.current_length = rrl_r;
                res_nxt.last           = (rbl_r == LW'(1));
                state_nxt              = lprf_pkg::S_RDATA;
              end else if (fill == '0) begin
                res_nxt.status = lprf_pkg::ST_EMPTY;
              end else begin
                // Record start: fetch the low header byte first.
                mem_req.re    = 1'b1;
                mem_req.raddr = rp_r[AW-1:0];
                state_nxt     = lprf_pkg::S_HLO;
              end
            end
            default: begin
              res_nxt.status = lprf_pkg::ST_OK;
            end
          endcase
        end
      end

      lprf_pkg::S_HDR: begin
        // Remaining header bytes: length high byte, then two zero bytes.
        mem_req.we    = 1'b1;
        mem_req.waddr = hdr_ptr[AW-1:0];
        mem_req.wdata = (hdr_cnt_r == 2'd1) ? 8'(hdr_len_r[LW-1:8]) : 8'd0;
        hdr_cnt_nxt   = hdr_cnt_r + 2'd1;
        if (hdr_cnt_r == 2'(lprf_pkg::HDR_BYTES - 1)) begin
          state_nxt = lprf_pkg::S_OUT;
        end
      end

      lprf_pkg::S_HLO: begin
        hdr_lo_nxt    = mem_rdata;
        mem_req.re    = 1'b1;
        mem_req.raddr = AW'(rp_r[AW-1:0] + AW'(1));
        state_nxt     = lprf_pkg::S_HHI;
      end

      lprf_pkg::S_HHI: begin
        // Upper two header bytes are always written as zero.
        if (hdr_bad) begin
          rp_nxt         = cwp_r;
          res_nxt.status = lprf_pkg::ST_CORRUPT;
          state_nxt      = lprf_pkg::S_OUT;
        end else begin
          mem_req.re             = 1'b1;
          mem_req.raddr          = AW'(rp_r[AW-1:0] + AW'(lprf_pkg::HDR_BYTES));
          rp_nxt                 = rp_r + PW'(lprf_pkg::HDR_BYTES + 1);
          rrl_nxt                = LW'(hdr_val);
          rbl_nxt                = LW'(hdr_val) - LW'(1);
          res_nxt.current_length = LW'(hdr_val);
          res_nxt.last           = (hdr_val == 16'd1);
          state_nxt              = lprf_pkg::S_RDATA;
        end
      end

      lprf_pkg::S_RDATA: begin
        res_nxt.read_data = mem_rdata;
        state_nxt         = lprf_pkg::S_OUT;
      end

      lprf_pkg::S_OUT: begin
        // Hand the result to the output register once it has room.
        if (out_free) begin
          out_data_nxt            = res_r;
          out_data_nxt.fill_level = fill;
          out_valid_nxt           = 1'b1;
          state_nxt               = lprf_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lprf_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lprf_pkg::S_IDLE;
      cwp_r       <= '0;
      swp_r       <= '0;
      wbl_r       <= '0;
      wopen_r     <= 1'b0;
      rp_r        <= '0;
      rbl_r       <= '0;
      rrl_r       <= '0;
      hdr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cwp_r       <= cwp_nxt;
      swp_r       <= swp_nxt;
      wbl_r       <= wbl_nxt;
      wopen_r     <= wopen_nxt;
      rp_r        <= rp_nxt;
      rbl_r       <= rbl_nxt;
      rrl_r       <= rrl_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hdr_len_r  <= hdr_len_nxt;
    hdr_lo_r   <= hdr_lo_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the pointer bookkeeping and the output hand-off.
  `LPRF_ASSERT_ALWAYS(a_fill_bound, fill <= PW'(lprf_pkg::STORE_BYTES), "fill exceeds store")
  `LPRF_ASSERT_ALWAYS(a_closed_no_staging, wopen_r || (swp_r == cwp_r), "staged bytes left")
  `LPRF_ASSERT_ALWAYS(a_read_left_bound, rbl_r <= rrl_r, "read count exceeds record length")
  `LPRF_ASSERT_NEXT(a_result_loads, (state_r == lprf_pkg::S_OUT) && !out_valid_r,
                    out_valid_r && (state_r == lprf_pkg::S_IDLE), "result not loaded")

endmodule
